// ----- design/lfc_pkg.sv -----
`timescale 1ns / 1ps
package lfc_pkg;

  localparam logic [7:0] CharNl = 8'h0A;
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharBs = 8'h5C;

  localparam int unsigned CountW         = 13;
  localparam int unsigned BufferBytesDef = 8192;
  localparam logic [CountW-1:0] MaxChunkRst = 13'd511;
  localparam logic [CountW-1:0] CountMax    = {CountW{1'b1}};

  typedef enum logic [1:0] {
    FUNC_DATA    = 2'd0,
    FUNC_EOS     = 2'd1,
    FUNC_DISCARD = 2'd2
  } func_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              last;
  } emit_t;

  // one byte into the open chunk: bump the count and decide whether it closes
  function automatic emit_t lfc_emit(logic [CountW-1:0] cnt, logic [7:0] b,
                                     logic [CountW-1:0] lim);
    logic [CountW:0] nxt;
    emit_t           e;
    nxt    = {1'b0, cnt} + {{CountW{1'b0}}, 1'b1};
    e.last = (b == CharNl) || (b == CharCr) || (nxt >= {1'b0, lim});
    e.count = e.last ? '0 : nxt[CountW-1:0];
    return e;
  endfunction

endpackage

// ----- design/line_framer_with_continuation.sv -----
`timescale 1ns / 1ps
// results are written into the result queue register before they appear on the master side
// throughput: one input request per cycle; results leave at one per cycle while
// the receiver is ready, through a four-entry result queue; a request may yield
// two results, and input ready drops while more than two results are queued
// reset: rst_ni clears chunk state and queue at once; max_chunk returns to 511
module line_framer_with_continuation #(
  parameter int unsigned BufferBytes = lfc_pkg::BufferBytesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lfc_pkg::CountW-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // data_byte
  input  logic [1:0]                s_axis_tuser,   // func
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // out_byte
  output logic                      m_axis_tuser,   // has_byte
  output logic                      m_axis_tlast
);

  localparam int unsigned CW = lfc_pkg::CountW;
  localparam logic [CW-1:0] CapLim =
    (BufferBytes - 1 > int'(lfc_pkg::CountMax)) ? lfc_pkg::CountMax : CW'(BufferBytes - 1);

  logic [CW-1:0] max_chunk_q;
  logic          held_q, held_d;
  logic          par_q, par_d;
  logic [CW-1:0] cnt_q, cnt_d;

  lfc_pkg::result_t fifo_q [4];
  logic [1:0]       wr_ptr_q, rd_ptr_q;
  logic [2:0]       fill_q, fill_d;

  logic             s_acc, m_acc;
  logic [CW-1:0]    lim;
  lfc_pkg::emit_t   e_bs, e_b;
  logic [CW-1:0]    c_mid;
  lfc_pkg::result_t r0, r1;
  logic [1:0]       n_push;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (fill_q <= 3'd2);
  assign m_axis_tvalid = (fill_q != 3'd0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q].data;
  assign m_axis_tuser  = fifo_q[rd_ptr_q].has_byte;
  assign m_axis_tlast  = fifo_q[rd_ptr_q].last;

  always_comb begin
    if (max_chunk_q > CapLim) begin
      lim = CapLim;
    end else if (max_chunk_q == '0) begin
      lim = {{(CW-1){1'b0}}, 1'b1};
    end else begin
      lim = max_chunk_q;
    end
  end

  assign e_bs  = lfc_pkg::lfc_emit(cnt_q, lfc_pkg::CharBs, lim);
  assign c_mid = held_q ? e_bs.count : cnt_q;
  assign e_b   = lfc_pkg::lfc_emit(c_mid, s_axis_tdata, lim);

  always_comb begin
    held_d = held_q;
    par_d  = par_q;
    cnt_d  = cnt_q;
    n_push = 2'd0;
    r0     = '{data: lfc_pkg::CharBs, has_byte: 1'b1, last: e_bs.last};
    r1     = '{data: s_axis_tdata, has_byte: 1'b1, last: e_b.last};
    case (s_axis_tuser)
      lfc_pkg::FUNC_DATA: begin
        if (s_axis_tdata == lfc_pkg::CharBs) begin
          if (held_q) begin
            n_push = 2'd1;
            cnt_d  = e_bs.count;
          end
          held_d = 1'b1;
          par_d  = ~par_q;
        end else if (held_q && s_axis_tdata == lfc_pkg::CharNl && par_q) begin
          // escaped newline: drop both
          held_d = 1'b0;
          par_d  = 1'b0;
        end else begin
          held_d = 1'b0;
          par_d  = 1'b0;
          cnt_d  = e_b.count;
          if (held_q) begin
            n_push = 2'd2;
          end else begin
            n_push = 2'd1;
            r0     = r1;
          end
        end
      end
      lfc_pkg::FUNC_EOS: begin
        if (held_q) begin
          n_push = 2'd1;
          r0     = '{data: lfc_pkg::CharBs, has_byte: 1'b1, last: 1'b1};
        end else if (cnt_q != '0) begin
          n_push = 2'd1;
          r0     = '{data: 8'h00, has_byte: 1'b0, last: 1'b1};
        end
        held_d = 1'b0;
        par_d  = 1'b0;
        cnt_d  = '0;
      end
      lfc_pkg::FUNC_DISCARD: begin
        held_d = 1'b0;
        par_d  = 1'b0;
        cnt_d  = '0;
      end
      default: begin
      end
    endcase
    if (!s_acc) begin
      held_d = held_q;
      par_d  = par_q;
      cnt_d  = cnt_q;
      n_push = 2'd0;
    end
  end

  assign fill_d = fill_q + {1'b0, n_push} - {2'b00, m_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chunk_q <= lfc_pkg::MaxChunkRst;
      held_q      <= 1'b0;
      par_q       <= 1'b0;
      cnt_q       <= '0;
      wr_ptr_q    <= 2'd0;
      rd_ptr_q    <= 2'd0;
      fill_q      <= 3'd0;
    end else begin
      if (cfg_we_i) begin
        max_chunk_q <= cfg_wdata_i;
      end
      held_q   <= held_d;
      par_q    <= par_d;
      cnt_q    <= cnt_d;
      wr_ptr_q <= wr_ptr_q + n_push;
      rd_ptr_q <= rd_ptr_q + {1'b0, m_acc};
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= r0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + 2'd1] <= r1;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 3'd4)
    else $error("result queue overfilled");

  a_count_below_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CapLim)
    else $error("open chunk count reached the buffer cap");

  a_parity_only_when_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> !par_q)
    else $error("run parity set with no held backslash");

  a_discard_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tuser == lfc_pkg::FUNC_DISCARD) |=>
      (!held_q && cnt_q == '0 && fill_q <= $past(fill_q)))
    else $error("discard left chunk state or pushed a result");
`endif

endmodule

// ----- dv/lfc_checker.sv -----
`timescale 1ns / 1ps
module lfc_checker
  import lfc_pkg::*;
#(
  parameter int unsigned BufferBytes = BufferBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              s_valid_i,
  input  logic              s_ready_i,
  input  logic [7:0]        s_data_i,
  input  logic [1:0]        s_func_i,
  input  logic              m_valid_i,
  input  logic              m_ready_i,
  input  logic [7:0]        m_data_i,
  input  logic              m_has_byte_i,
  input  logic              m_last_i,
  output int                fail_count_o,
  output int                pending_o
);

  logic [CountW-1:0] chunk_max;
  logic [CountW-1:0] open_len;
  logic              held_bs;
  logic              bs_odd;
  result_t           chunk_results_q[$];
  result_t           want;
  result_t           seen;
  int                mismatches;

  function automatic logic [CountW-1:0] chunk_limit();
    int unsigned lim;
    lim = 32'(chunk_max);
    if (lim > BufferBytes - 1) lim = BufferBytes - 1;
    if (lim == 0) lim = 1;
    return lim[CountW-1:0];
  endfunction

  task automatic push_chunk_byte(input logic [7:0] b);
    result_t r;
    open_len   = open_len + CountW'(1);
    r.data     = b;
    r.has_byte = 1'b1;
    r.last     = (b == CharNl) || (b == CharCr) || (open_len >= chunk_limit());
    if (r.last) open_len = '0;
    chunk_results_q.push_back(r);
  endtask

  task automatic clear_chunk();
    held_bs  = 1'b0;
    bs_odd   = 1'b0;
    open_len = '0;
  endtask

  // work out the chunk results caused by one request
  task automatic frame_request(input logic [1:0] f, input logic [7:0] b);
    result_t r;
    case (f)
      FUNC_DISCARD: begin
        clear_chunk();
      end
      FUNC_EOS: begin
        if (held_bs) begin
          r = '{data: CharBs, has_byte: 1'b1, last: 1'b1};
          chunk_results_q.push_back(r);
        end else if (open_len != '0) begin
          r = '{data: 8'h00, has_byte: 1'b0, last: 1'b1};
          chunk_results_q.push_back(r);
        end
        clear_chunk();
      end
      FUNC_DATA: begin
        if (b == CharBs) begin
          if (held_bs) push_chunk_byte(CharBs);
          held_bs = 1'b1;
          bs_odd  = ~bs_odd;
        end else if (held_bs && b == CharNl && bs_odd) begin
          // line continuation
          held_bs = 1'b0;
          bs_odd  = 1'b0;
        end else begin
          if (held_bs) begin
            push_chunk_byte(CharBs);
            held_bs = 1'b0;
          end
          bs_odd = 1'b0;
          push_chunk_byte(b);
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch (%s): exp data=%h has=%b last=%b, got data=%h has=%b last=%b",
               $time, what, want.data, want.has_byte, want.last,
               seen.data, seen.has_byte, seen.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_max = MaxChunkRst;
      clear_chunk();
      chunk_results_q.delete();
      mismatches = 0;
      want = '0;
      seen = '0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        seen = '{data: m_data_i, has_byte: m_has_byte_i, last: m_last_i};
        if (chunk_results_q.size() == 0) begin
          want = '0;
          note_mismatch("unexpected result");
        end else begin
          want = chunk_results_q.pop_front();
          if (seen.data != want.data || seen.has_byte != want.has_byte ||
              seen.last != want.last) begin
            note_mismatch("field");
          end
        end
      end
      if (s_valid_i && s_ready_i) frame_request(s_func_i, s_data_i);
      if (cfg_we_i) chunk_max = cfg_wdata_i;
      pending_o <= chunk_results_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import lfc_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int         QuietLimit = 20000;
  localparam int         HoldCycles = 400;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CountW-1:0] cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = 8'h00;
  logic [1:0]        s_axis_tuser = 2'd0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tuser;
  logic              m_axis_tlast;

  int fail_count;
  int pending;
  int burst_left = 0;
  int quiet = 0;
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int max_list[6];

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  line_framer_with_continuation u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  lfc_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_func_i    (s_axis_tuser),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_has_byte_i(m_axis_tuser),
    .m_last_i    (m_axis_tlast),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    rx_cycle++;
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 150) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 9) < 7);
        2: m_axis_tready <= ($urandom_range(0, 9) < 3);
        default: m_axis_tready <= ((rx_cycle % 7) < 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [1:0] f, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 2);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_request(FUNC_DATA, b);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_max_chunk(input int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[CountW-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // mostly text with backslash runs and line ends, some stream ends, discards and unused function codes
  task automatic random_stream(input int n);
    int          sent;
    int          r;
    logic [7:0]  b;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      b = 8'($urandom_range(0, 255));
      if (r < 2) begin
        send_request(FUNC_DISCARD, b);
        sent++;
      end else if (r < 7) begin
        send_request(FUNC_EOS, b);
        sent++;
      end else if (r < 8) begin
        send_request(FuncUnused, b);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) b = CharBs;
        else if (r < 42) b = CharNl;
        else if (r < 47) b = CharCr;
        send_byte(b);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CharNl);
    send_byte(CharCr);
    send_byte(CharBs);
    send_byte(CharNl);
    send_byte(CharBs);
    send_byte(CharBs);
    send_byte(CharNl);
    send_byte(CharBs);
    send_byte(CharBs);
    send_byte(CharBs);
    send_byte(CharNl);
    send_byte(CharBs);
    send_byte(8'h78);
    send_byte(CharBs);
    send_request(FUNC_EOS, 8'hAA);
    send_byte(8'h79);
    send_request(FUNC_EOS, 8'h55);
    send_request(FUNC_EOS, 8'h00);
    send_byte(8'h7A);
    send_byte(CharBs);
    send_request(FUNC_DISCARD, 8'hFF);
    send_request(FuncUnused, 8'h0A);
    send_byte(CharNl);
    wait_idle();

    max_list = '{1, 8191, 2, 5, 13, 0};
    max_list[5] = $urandom_range(3, 40);
    foreach (max_list[i]) begin
      write_max_chunk(max_list[i]);
      if (i == 2) hold_req = 1'b1;
      random_stream(140);
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
